### rtl/idl48_pkg.sv
// Shared constants for the IEEE double / 48-bit legacy float converter.
// No dependencies.
package idl48_pkg;

  localparam int unsigned MantBits = 40;
  localparam int unsigned MantW    = 41;
  localparam int unsigned ExpW     = 7;
  localparam int unsigned WordW    = 48;
  localparam int unsigned DataW    = 64;

  localparam logic [WordW-1:0] SatPos   = 48'hFEFF_FFFF_FFFF;
  localparam logic [WordW-1:0] SatNeg   = 48'hFF00_0000_0000;
  localparam logic [WordW-1:0] ZeroWord = 48'h8000_0000_0000;

  localparam logic [1:0] StNormal = 2'd0;
  localparam logic [1:0] StFlush  = 2'd1;
  localparam logic [1:0] StSat    = 2'd2;
  localparam logic [1:0] StNan    = 2'd3;

  localparam logic ModeToLegacy = 1'b0;
  localparam logic ModeToIeee   = 1'b1;

endpackage

### rtl/ieee_double_legacy48_float_converter_core.sv
// IEEE double <-> 48-bit legacy float converter, one beat per cycle.
// Uses idl48_pkg.
//
// Usage:
//   A beat (mode_i, operand_i) is taken at each rising edge with start_i
//   high and busy_o low. busy_o is tied low: a beat may enter every cycle.
//   Mode 0 turns IEEE double bits into a legacy word (bits 47..0 of
//   result_o), mode 1 turns the low 48 operand bits into IEEE double bits.
//   status_o: 0 normal, 1 flushed, 2 saturated, 3 NaN (mode 1 gives 0).
// Pipeline: operand register, then one pass of conversion logic into the
//   result register; done_o pulses for one cycle as the result register loads.
// Throughput: one beat per cycle, bounded only by the single conversion
//   pass between the two registers.
// Reset: rst_ni (async, low) clears the valid pipeline; no beat in flight
//   is delivered.
// The receiver cannot stall; each result is shown for exactly one cycle.
module ieee_double_legacy48_float_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [63:0] operand_i,
  output logic        done_o,
  output logic [63:0] result_o,
  output logic [1:0]  status_o
);

  logic        vld_q;
  logic        mode_q;
  logic [63:0] op_q;
  logic        done_q;
  logic [63:0] res_q, res_d;
  logic [1:0]  st_q, st_d;

  assign busy_o = 1'b0;

  // forward path
  logic        f_neg;
  logic [10:0] f_bexp;
  logic [51:0] f_frac;
  logic [52:0] f_sig;
  logic [40:0] f_w;
  logic [11:0] f_ex;    // signed, ex = bexp - 1022 (+1)
  logic [40:0] f_mant;
  logic [47:0] f_word;
  logic [1:0]  f_st;

  // reverse path
  logic [6:0]  r_e;
  logic [40:0] r_m, r_a, r_norm;
  logic        r_neg;
  logic [5:0]  r_p;
  logic [10:0] r_bexp;
  logic [63:0] r_res;

  always_comb begin
    f_neg  = op_q[63];
    f_bexp = op_q[62:52];
    f_frac = op_q[51:0];
    f_sig  = {1'b1, f_frac};
    f_w    = {1'b0, f_sig[52:13]} + {40'd0, f_sig[12]};
    f_ex   = $signed({1'b0, f_bexp}) - 12'sd1022;
    if (!f_neg && f_w[40]) begin
      f_w  = {1'b0, f_w[40:1]};
      f_ex = f_ex + 12'd1;
    end
    f_mant = f_neg ? (41'd0 - f_w) : f_w;
    f_word = 48'd0;
    f_st   = idl48_pkg::StNormal;
    if (f_bexp == 11'h7FF) begin
      if (f_frac != 52'd0) begin
        f_word = idl48_pkg::SatPos;
        f_st   = idl48_pkg::StNan;
      end else begin
        f_word = f_neg ? idl48_pkg::SatNeg : idl48_pkg::SatPos;
        f_st   = idl48_pkg::StSat;
      end
    end else if (f_bexp == 11'd0) begin
      if (f_frac == 52'd0) begin
        f_word = idl48_pkg::ZeroWord;
      end else begin
        f_st = idl48_pkg::StFlush;
      end
    end else if ($signed(f_ex) < -12'sd64) begin
      f_st = idl48_pkg::StFlush;
    end else if ($signed(f_ex) > 12'sd63) begin
      f_word = f_neg ? idl48_pkg::SatNeg : idl48_pkg::SatPos;
      f_st   = idl48_pkg::StSat;
    end else begin
      f_word = {f_ex[6:0] + 7'd64, f_mant};
    end
  end

  always_comb begin
    r_e   = op_q[47:41];
    r_m   = op_q[40:0];
    r_neg = r_m[40];
    r_a   = r_neg ? (41'd0 - r_m) : r_m;
    r_p   = 6'd0;
    for (int i = 0; i < idl48_pkg::MantW; i++) begin
      if (r_a[i]) r_p = 6'(i);
    end
    r_norm = r_a << (6'd40 - r_p);
    r_bexp = {5'd0, r_p} + {4'd0, r_e} + 11'd919;
    r_res  = {r_neg, r_bexp, r_norm[39:0], 12'd0};
    if (r_m == 41'd0) r_res = 64'd0;
  end

  always_comb begin
    if (mode_q == idl48_pkg::ModeToIeee) begin
      res_d = r_res;
      st_d  = idl48_pkg::StNormal;
    end else begin
      res_d = {16'd0, f_word};
      st_d  = f_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start_i & ~busy_o;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      mode_q <= mode_i;
      op_q   <= operand_i;
    end
    if (vld_q) begin
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;
  assign status_o = st_q;

endmodule

### rtl/idl48_checker.sv
// Port-level checks for the converter core, attached by bind.
// Uses idl48_pkg.
module idl48_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        mode_i,
  input logic        done_o,
  input logic [63:0] result_o,
  input logic [1:0]  status_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("beat not delivered two cycles after accept");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result strobe without an accepted beat");

  a_ieee_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(mode_i == idl48_pkg::ModeToIeee, 2) |-> status_o == idl48_pkg::StNormal)
    else $error("nonzero status in reverse mode");

  a_legacy_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(mode_i == idl48_pkg::ModeToLegacy, 2) |-> result_o[63:48] == 16'd0)
    else $error("legacy word has upper bits set");

endmodule

bind ieee_double_legacy48_float_converter_core idl48_checker u_idl48_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .mode_i   (mode_i),
  .done_o   (done_o),
  .result_o (result_o),
  .status_o (status_o)
);

### bench/tb_top.sv
// Testbench for the IEEE double / 48-bit legacy float converter core.
// Self-checking: queued beats are driven, results are checked against a local predictor.
// Depends on idl48_pkg and ieee_double_legacy48_float_converter_core.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic        mode;
    logic [63:0] operand;
  } beat_t;

  typedef struct packed {
    logic [63:0] result;
    logic [1:0]  status;
  } conv_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        mode_i = 1'b0;
  logic [63:0] operand_i = '0;
  logic        busy_o, done_o;
  logic [63:0] result_o;
  logic [1:0]  status_o;

  beat_t pending_q[$];
  conv_t conv_expected_q[$];
  int    n_errors = 0;
  int    n_checked = 0;
  int    n_to_legacy = 0;
  int    n_to_ieee = 0;
  bit    calm = 1'b0;

  ieee_double_legacy48_float_converter_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .operand_i,
    .done_o, .result_o, .status_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic conv_t convert(beat_t b);
    conv_t       r;
    logic        neg;
    logic [10:0] bexp;
    logic [51:0] frac;
    logic [52:0] sig;
    logic [40:0] w, m, a;
    logic [6:0]  e;
    int          ex, p;
    r.status = idl48_pkg::StNormal;
    r.result = '0;
    if (b.mode == idl48_pkg::ModeToLegacy) begin
      neg  = b.operand[63];
      bexp = b.operand[62:52];
      frac = b.operand[51:0];
      if (bexp == 11'h7FF) begin
        r.result = (frac != 0 || !neg) ? {16'h0, idl48_pkg::SatPos}
                                       : {16'h0, idl48_pkg::SatNeg};
        r.status = (frac != 0) ? idl48_pkg::StNan : idl48_pkg::StSat;
      end else if (bexp == 0) begin
        r.result = (frac == 0) ? {16'h0, idl48_pkg::ZeroWord} : '0;
        r.status = (frac == 0) ? idl48_pkg::StNormal : idl48_pkg::StFlush;
      end else begin
        ex  = int'(bexp) - 1022;
        sig = {1'b1, frac};
        w   = {1'b0, sig[52:13]} + {40'd0, sig[12]};
        // positive carry renormalizes; negative carry stays as -2^40
        if (!neg && w[40]) begin
          w  = w >> 1;
          ex = ex + 1;
        end
        if (ex < -64) begin
          r.status = idl48_pkg::StFlush;
        end else if (ex > 63) begin
          r.result = neg ? {16'h0, idl48_pkg::SatNeg} : {16'h0, idl48_pkg::SatPos};
          r.status = idl48_pkg::StSat;
        end else begin
          if (neg) w = -w;
          e = 7'(ex + 64);
          r.result = {16'h0, e, w};
        end
      end
    end else begin
      e = b.operand[47:41];
      m = b.operand[40:0];
      if (m != 0) begin
        neg = m[40];
        a   = neg ? -m : m;
        // negating -2^40 wraps back to -2^40, whose magnitude bit 40 is set anyway
        p = 40;
        while (p > 0 && !a[p]) p--;
        r.result[63]    = neg;
        r.result[62:52] = 11'(p + int'(e) - 104 + 1023);
        r.result[51:0]  = 52'({11'h0, a} << (52 - p));
      end
    end
    return r;
  endfunction

  // Driver: beats change on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        // previous beat taken on the last rising edge
      end
      if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
        beat_t b;
        b = pending_q.pop_front();
        start_i   <= 1'b1;
        mode_i    <= b.mode;
        operand_i <= b.operand;
        conv_expected_q.push_back(convert(b));
        if (b.mode == idl48_pkg::ModeToLegacy) n_to_legacy++; else n_to_ieee++;
      end else begin
        start_i   <= 1'b0;
        mode_i    <= 1'($urandom_range(1));
        operand_i <= {$urandom, $urandom};
      end
    end
  end

  // busy_o is tied low, so every raised start is one accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni && busy_o && start_i) begin
      $display("%0t: busy_o high while driving a beat", $time);
      n_errors++;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (conv_expected_q.size() == 0) begin
        $display("%0t: unexpected result %h status %0d", $time, result_o, status_o);
        n_errors++;
      end else begin
        conv_t x;
        x = conv_expected_q.pop_front();
        n_checked++;
        if (result_o !== x.result) begin
          $display("%0t: result exp %h got %h", $time, x.result, result_o);
          n_errors++;
        end
        if (status_o !== x.status) begin
          $display("%0t: status exp %0d got %0d", $time, x.status, status_o);
          n_errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_double();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(9))
      0: d[62:52] = 11'h7FF;
      1: d[62:52] = 11'h0;
      2: d[62:52] = 11'(1022 - 64 + $urandom_range(3) - 1);
      3: d[62:52] = 11'(1022 + 63 + $urandom_range(2) - 1);
      4: d[51:13] = '1;
      5: d[51:0]  = '0;
      default: d[62:52] = 11'(1022 + $urandom_range(127) - 64);
    endcase
    return d;
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(5))
      0: d[40:0] = '0;
      1: d[40:0] = {1'b1, 40'h0};
      2: d[40:0] = 41'($urandom_range(255));
      3: d[40:0] = -41'($urandom_range(255));
      default: ;
    endcase
    return d;
  endfunction

  initial begin
    logic [63:0] directed[$];
    int k;
    directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                 64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                 64'h800F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
                 64'h3FFF_FFFF_FFFF_F000, 64'hBFFF_FFFF_FFFF_F000,
                 64'h3BE0_0000_0000_0000, 64'h3BDF_FFFF_FFFF_F000,
                 64'h43DF_FFFF_FFFF_F000, 64'h43E0_0000_0000_0000,
                 64'h3FF0_0000_0000_1000};
    foreach (directed[i]) pending_q.push_back('{idl48_pkg::ModeToLegacy, directed[i]});
    directed = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_0000_0000_0000,
                 64'h0000_0100_0000_0000, 64'h0000_01FF_FFFF_FFFF,
                 64'h0000_FE00_0000_0001, 64'h0000_7FFF_FFFF_FFFF,
                 64'h0000_8000_0000_0001};
    foreach (directed[i]) pending_q.push_back('{idl48_pkg::ModeToIeee, directed[i]});
    for (k = 0; k < 650; k++) begin
      if ($urandom_range(1)) pending_q.push_back('{idl48_pkg::ModeToLegacy, rand_double()});
      else pending_q.push_back('{idl48_pkg::ModeToIeee, rand_word()});
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    repeat (200) @(posedge clk_i);
    calm = 1'b1;
    repeat (150) @(posedge clk_i);
    calm = 1'b0;
    wait (pending_q.size() == 0);
    @(negedge clk_i);
    wait (conv_expected_q.size() == 0);
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results: %0d double-to-legacy, %0d legacy-to-double beats.",
             n_checked, n_to_legacy, n_to_ieee);
    if (n_errors == 0 && conv_expected_q.size() == 0) begin
      $display("** ieee_double_legacy48_float_converter_core: PASSED **");
    end else begin
      $display("** ieee_double_legacy48_float_converter_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Timeout with %0d results outstanding.", conv_expected_q.size());
    $display("** ieee_double_legacy48_float_converter_core: FAILED **");
    $finish;
  end

endmodule
